### sv/sexp_pkg.sv
// Shared types and constants for the s-expression lexer.
`timescale 1ns / 1ps
`default_nettype none

package sexp_pkg;

   // Input item: one source byte or the end-of-input mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   // Result item
   typedef struct packed {
      logic [3:0]         token_kind;
      logic               is_text_byte;
      logic [7:0]         text_byte;
      logic signed [63:0] int_value;
      logic               last;
   } rsp_type;

   // One result without its integer value
   typedef struct packed {
      logic [3:0] kind;
      logic       is_text;
      logic [7:0] text;
   } slot_type;

   localparam int unsigned MAX_RESULTS = 4;

   // All results of one input item; the integer value only ever rides in slot 0
   typedef struct packed {
      logic [1:0]                       last_idx;
      slot_type [MAX_RESULTS-1:0]       slots;
      logic [63:0]                      int_value;
   } bundle_type;

   // Token kinds
   localparam logic [3:0] KIND_SYMBOL  = 4'd0;
   localparam logic [3:0] KIND_INT     = 4'd1;
   localparam logic [3:0] KIND_REAL    = 4'd2;
   localparam logic [3:0] KIND_STRING  = 4'd3;
   localparam logic [3:0] KIND_CHAR    = 4'd4;
   localparam logic [3:0] KIND_OPENP   = 4'd5;
   localparam logic [3:0] KIND_CLOSEP  = 4'd6;
   localparam logic [3:0] KIND_OPENB   = 4'd7;
   localparam logic [3:0] KIND_CLOSEB  = 4'd8;
   localparam logic [3:0] KIND_QUOTE   = 4'd9;
   localparam logic [3:0] KIND_DOT     = 4'd10;
   localparam logic [3:0] KIND_END     = 4'd11;
   localparam logic [3:0] KIND_BADCHAR = 4'd12;

   // Characters
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_OPENP   = 8'h28;
   localparam logic [7:0] CH_CLOSEP  = 8'h29;
   localparam logic [7:0] CH_OPENB   = 8'h5B;
   localparam logic [7:0] CH_CLOSEB  = 8'h5D;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Integer magnitude limits
   localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

### sv/sexp_front.sv
// Front end: classifies each byte and builds the bundle of results it causes.
`timescale 1ns / 1ps
`default_nettype none

module sexp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire sexp_pkg::req_type    req,
   input  wire logic                 queue_full,
   output logic                      push,
   output sexp_pkg::bundle_type      push_data
);

   // Lexer modes
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_MINUS   = 4'd1;
   localparam logic [3:0] M_DOT     = 4'd2;
   localparam logic [3:0] M_SYMBOL  = 4'd3;
   localparam logic [3:0] M_NUMBER  = 4'd4;
   localparam logic [3:0] M_STRING  = 4'd5;
   localparam logic [3:0] M_STRESC  = 4'd6;
   localparam logic [3:0] M_HASH    = 4'd7;
   localparam logic [3:0] M_HASHOK  = 4'd8;
   localparam logic [3:0] M_HASHBAD = 4'd9;
   localparam logic [3:0] M_COMMENT = 4'd10;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= sexp_pkg::CH_ZERO) && (c <= sexp_pkg::CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // Characters shared by symbol start and symbol continuation
   function automatic logic sym_punct(input logic [7:0] c);
      return (c == 8'h2B) || (c == 8'h2A) || (c == 8'h2F) || (c == 8'h25) ||
             (c == 8'h21) || (c == 8'h3F) || (c == 8'h26) || (c == 8'h5E) ||
             (c == 8'h7C) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h3D);
   endfunction

   function automatic logic sym_start(input logic [7:0] c);
      return is_alpha(c) || sym_punct(c) || (c == 8'h24);
   endfunction

   function automatic logic sym_more(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || sym_punct(c) ||
             (c == sexp_pkg::CH_BSLASH) || (c == sexp_pkg::CH_MINUS);
   endfunction

   function automatic sexp_pkg::slot_type mk(input logic [3:0] kind, input logic is_text,
                                             input logic [7:0] text);
      sexp_pkg::slot_type s;
      s.kind    = kind;
      s.is_text = is_text;
      s.text    = text;
      return s;
   endfunction

   logic [3:0]  mode_ff, mode_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        dec_ff, dec_in;

   logic                                        accept;
   logic [7:0]                                  c;
   logic                                        do_idle;
   logic [2:0]                                  n;
   sexp_pkg::slot_type [sexp_pkg::MAX_RESULTS-1:0] slots;
   logic [63:0]                                 int_val;
   logic [67:0]                                 prod;
   logic                                        sat;
   logic [63:0]                                 acc_digit;
   logic [63:0]                                 num_val;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign c         = req.data_byte;

   // Accumulate one decimal digit: acc * 10 + d, capped at 2^63
   assign prod      = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + {64'd0, c[3:0]};
   assign sat       = prod > {4'd0, sexp_pkg::MAG_LIMIT};
   assign acc_digit = sat ? sexp_pkg::MAG_LIMIT : prod[63:0];

   // Value of a completed integer, saturated to the signed range
   assign num_val = neg_ff ? (64'd0 - acc_ff) : (acc_ff[63] ? sexp_pkg::POS_MAX : acc_ff);

   // Step the lexer over one item
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      dec_in  = dec_ff;
      slots   = '0;
      n       = 3'd0;
      int_val = '0;
      do_idle = 1'b0;
      if (req.end_of_input) begin
         // Finish the pending token, then emit end
         unique case (mode_ff)
            M_MINUS: begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, sexp_pkg::CH_MINUS);
               n = n + 3'd1;
               slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b0, 8'd0);
               n = n + 3'd1;
            end
            M_DOT: begin
               if (neg_ff) begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, sexp_pkg::CH_MINUS);
                  n = n + 3'd1;
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b0, 8'd0);
                  n = n + 3'd1;
               end
               slots[n[1:0]] = mk(sexp_pkg::KIND_DOT, 1'b0, 8'd0);
               n = n + 3'd1;
            end
            M_SYMBOL: begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b0, 8'd0);
               n = n + 3'd1;
            end
            M_NUMBER: begin
               if (dec_ff) begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_REAL, 1'b0, 8'd0);
               end else begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_INT, 1'b0, 8'd0);
                  int_val = num_val;
               end
               n = n + 3'd1;
            end
            M_STRING, M_STRESC: begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_STRING, 1'b0, 8'd0);
               n = n + 3'd1;
            end
            M_HASH, M_HASHOK, M_HASHBAD: begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_BADCHAR, 1'b0, 8'd0);
               n = n + 3'd1;
            end
            default: begin
            end
         endcase
         slots[n[1:0]] = mk(sexp_pkg::KIND_END, 1'b0, 8'd0);
         n = n + 3'd1;
         mode_in = M_IDLE;
         acc_in  = '0;
         neg_in  = 1'b0;
         dec_in  = 1'b0;
      end else begin
         unique case (mode_ff)
            M_MINUS: begin
               if (is_digit(c)) begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_INT, 1'b1, sexp_pkg::CH_MINUS);
                  n = n + 3'd1;
                  slots[n[1:0]] = mk(sexp_pkg::KIND_INT, 1'b1, c);
                  n = n + 3'd1;
                  mode_in = M_NUMBER;
                  acc_in  = {60'd0, c[3:0]};
                  dec_in  = 1'b0;
                  neg_in  = 1'b1;
               end else if (sym_start(c)) begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, sexp_pkg::CH_MINUS);
                  n = n + 3'd1;
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, c);
                  n = n + 3'd1;
                  mode_in = M_SYMBOL;
               end else if (c == sexp_pkg::CH_DOT) begin
                  neg_in  = 1'b1;
                  mode_in = M_DOT;
               end else begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, sexp_pkg::CH_MINUS);
                  n = n + 3'd1;
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b0, 8'd0);
                  n = n + 3'd1;
                  do_idle = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit(c)) begin
                  if (neg_ff) begin
                     slots[n[1:0]] = mk(sexp_pkg::KIND_REAL, 1'b1, sexp_pkg::CH_MINUS);
                     n = n + 3'd1;
                  end
                  slots[n[1:0]] = mk(sexp_pkg::KIND_REAL, 1'b1, sexp_pkg::CH_DOT);
                  n = n + 3'd1;
                  slots[n[1:0]] = mk(sexp_pkg::KIND_REAL, 1'b1, c);
                  n = n + 3'd1;
                  mode_in = M_NUMBER;
                  dec_in  = 1'b1;
               end else begin
                  if (neg_ff) begin
                     slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, sexp_pkg::CH_MINUS);
                     n = n + 3'd1;
                     slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b0, 8'd0);
                     n = n + 3'd1;
                  end
                  slots[n[1:0]] = mk(sexp_pkg::KIND_DOT, 1'b0, 8'd0);
                  n = n + 3'd1;
                  do_idle = 1'b1;
               end
            end
            M_SYMBOL: begin
               if (sym_more(c)) begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, c);
                  n = n + 3'd1;
               end else begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b0, 8'd0);
                  n = n + 3'd1;
                  do_idle = 1'b1;
               end
            end
            M_NUMBER: begin
               if (is_digit(c)) begin
                  if (!dec_ff) begin
                     acc_in = acc_digit;
                  end
                  slots[n[1:0]] = mk(dec_ff ? sexp_pkg::KIND_REAL : sexp_pkg::KIND_INT, 1'b1, c);
                  n = n + 3'd1;
               end else if ((c == sexp_pkg::CH_DOT) && !dec_ff) begin
                  dec_in = 1'b1;
                  slots[n[1:0]] = mk(sexp_pkg::KIND_REAL, 1'b1, c);
                  n = n + 3'd1;
               end else begin
                  if (dec_ff) begin
                     slots[n[1:0]] = mk(sexp_pkg::KIND_REAL, 1'b0, 8'd0);
                  end else begin
                     slots[n[1:0]] = mk(sexp_pkg::KIND_INT, 1'b0, 8'd0);
                     int_val = num_val;
                  end
                  n = n + 3'd1;
                  do_idle = 1'b1;
               end
            end
            M_STRING: begin
               if (c == sexp_pkg::CH_DQUOTE) begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_STRING, 1'b0, 8'd0);
                  n = n + 3'd1;
                  mode_in = M_IDLE;
               end else if (c == sexp_pkg::CH_BSLASH) begin
                  mode_in = M_STRESC;
               end else begin
                  slots[n[1:0]] = mk(sexp_pkg::KIND_STRING, 1'b1, c);
                  n = n + 3'd1;
               end
            end
            M_STRESC: begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_STRING, 1'b1, c);
               n = n + 3'd1;
               mode_in = M_STRING;
            end
            M_HASH: begin
               mode_in = (c == sexp_pkg::CH_BSLASH) ? M_HASHOK : M_HASHBAD;
            end
            M_HASHOK: begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_CHAR, 1'b0, c);
               n = n + 3'd1;
               mode_in = M_IDLE;
            end
            M_HASHBAD: begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_BADCHAR, 1'b0, c);
               n = n + 3'd1;
               mode_in = M_IDLE;
            end
            M_COMMENT: begin
               if (c == sexp_pkg::CH_NEWLINE) begin
                  mode_in = M_IDLE;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // Start a fresh token from this byte
         if (do_idle) begin
            neg_in  = 1'b0;
            dec_in  = 1'b0;
            acc_in  = '0;
            mode_in = M_IDLE;
            if (c == sexp_pkg::CH_MINUS) begin
               mode_in = M_MINUS;
            end else if (c == sexp_pkg::CH_DOT) begin
               mode_in = M_DOT;
            end else if (is_digit(c)) begin
               mode_in = M_NUMBER;
               acc_in  = {60'd0, c[3:0]};
               slots[n[1:0]] = mk(sexp_pkg::KIND_INT, 1'b1, c);
               n = n + 3'd1;
            end else if (sym_start(c)) begin
               mode_in = M_SYMBOL;
               slots[n[1:0]] = mk(sexp_pkg::KIND_SYMBOL, 1'b1, c);
               n = n + 3'd1;
            end else if (c == sexp_pkg::CH_OPENP) begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_OPENP, 1'b0, 8'd0);
               n = n + 3'd1;
            end else if (c == sexp_pkg::CH_CLOSEP) begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_CLOSEP, 1'b0, 8'd0);
               n = n + 3'd1;
            end else if (c == sexp_pkg::CH_OPENB) begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_OPENB, 1'b0, 8'd0);
               n = n + 3'd1;
            end else if (c == sexp_pkg::CH_CLOSEB) begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_CLOSEB, 1'b0, 8'd0);
               n = n + 3'd1;
            end else if (c == sexp_pkg::CH_SQUOTE) begin
               slots[n[1:0]] = mk(sexp_pkg::KIND_QUOTE, 1'b0, 8'd0);
               n = n + 3'd1;
            end else if (c == sexp_pkg::CH_DQUOTE) begin
               mode_in = M_STRING;
            end else if (c == sexp_pkg::CH_HASH) begin
               mode_in = M_HASH;
            end else if (c == sexp_pkg::CH_SEMI) begin
               mode_in = M_COMMENT;
            end
         end
      end
   end

   // Hand the bundle to the queue when the item caused any result
   assign push                = accept && (n != 3'd0);
   assign push_data.last_idx  = 2'(n - 3'd1);
   assign push_data.slots     = slots;
   assign push_data.int_value = int_val;

   // Commit lexer state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         acc_ff  <= '0;
         neg_ff  <= 1'b0;
         dec_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         neg_ff  <= neg_in;
         dec_ff  <= dec_in;
      end
   end

endmodule

`default_nettype wire

### sv/sexp_queue.sv
// Short queue of result bundles between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module sexp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire sexp_pkg::bundle_type  push_data,
   input  wire logic                  pop,
   output sexp_pkg::bundle_type       head,
   output logic                       full,
   output logic                       empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sexp_pkg::bundle_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store bundle payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/sexp_back.sv
// Back end: unpacks queued bundles into one registered result item per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module sexp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sexp_pkg::bundle_type  head,
   input  wire logic                  empty,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sexp_pkg::rsp_type          rsp
);

   logic [1:0]          slot_ff, slot_in;
   logic                valid_ff, valid_in;
   sexp_pkg::rsp_type   rsp_ff, rsp_in;
   logic                load;
   logic                is_last;
   sexp_pkg::slot_type  sel;

   assign load    = !empty && (!valid_ff || !rsp_stall);
   assign sel     = head.slots[slot_ff];
   assign is_last = (slot_ff == head.last_idx);
   assign pop     = load && is_last;

   // Pick the next result of the head bundle
   always_comb begin
      rsp_in.token_kind   = sel.kind;
      rsp_in.is_text_byte = sel.is_text;
      rsp_in.text_byte    = sel.text;
      rsp_in.int_value    = (slot_ff == 2'd0) ? $signed(head.int_value) : 64'sd0;
      rsp_in.last         = is_last;
      slot_in             = slot_ff;
      valid_in            = valid_ff;
      if (load) begin
         slot_in  = is_last ? 2'd0 : slot_ff + 2'd1;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the output item until it is taken
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

### sv/s_expression_lexer.sv
// Top level of the streaming s-expression lexer.
// The results of an item pass through the bundle queue and then the output register.
// Throughput: one item per cycle while the bundle queue is not full; an item that causes
// k results yields k output items, so the result port (one result per cycle while not
// stalled) sets the sustained rate. Items that cause no result never reach the queue.
// Reset clears the lexer mode, number state, bundle queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module s_expression_lexer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sexp_pkg::req_type  req,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sexp_pkg::rsp_type       rsp
);

   logic                 push;
   sexp_pkg::bundle_type push_data;
   logic                 pop;
   sexp_pkg::bundle_type head;
   logic                 full;
   logic                 empty;

   sexp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   sexp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   sexp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire
